@@ design/urc_pkg.sv @@
// shared types, constants and checksum helper for the udp receive checker
package urc_pkg;

    localparam int PORT_ENTRIES   = 4;
    localparam int REG_ENTRIES    = 4;
    localparam int SEARCH_ENTRIES = (PORT_ENTRIES < REG_ENTRIES) ? PORT_ENTRIES : REG_ENTRIES;

    localparam int BYTE_W       = 8;
    localparam int IP_W         = 32;
    localparam int WORD_W       = 16;
    localparam int COUNT_W      = 16;
    localparam int RECV_W       = COUNT_W + 1;
    localparam int IPSUM_W      = WORD_W + 1;
    localparam int ENTRY_W      = 2;
    localparam int VERDICT_W    = 3;
    localparam int PORT_ENTRY_W = WORD_W + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int TOTAL_W      = 20;

    localparam int S_FIELD_W = BYTE_W + IP_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = VERDICT_W + ENTRY_W + 3 * WORD_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam int HEADER_BYTES = 8;
    localparam int MIN_RECEIVED = 6;
    localparam int UDP_PROTOCOL = 17;

    // header byte positions
    localparam logic [COUNT_W-1:0] OFS_SRC_HI = 16'd0;
    localparam logic [COUNT_W-1:0] OFS_SRC_LO = 16'd1;
    localparam logic [COUNT_W-1:0] OFS_DST_HI = 16'd2;
    localparam logic [COUNT_W-1:0] OFS_DST_LO = 16'd3;
    localparam logic [COUNT_W-1:0] OFS_LEN_HI = 16'd4;
    localparam logic [COUNT_W-1:0] OFS_LEN_LO = 16'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_BASE = 3'd1;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_DELIVERED    = 3'd0,
        VERDICT_UNREACHABLE  = 3'd1,
        VERDICT_TOO_SHORT    = 3'd2,
        VERDICT_BAD_CHECKSUM = 3'd3,
        VERDICT_TRUNCATED    = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [IPSUM_W-1:0]                        local_ip_sum;
        logic [REG_ENTRIES-1:0][PORT_ENTRY_W-1:0]  port_entry;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0]  run_sum;
        logic [WORD_W-1:0]  pad_word;
        logic [IPSUM_W-1:0] ip_sum;
        logic [WORD_W-1:0]  source_port;
        logic [WORD_W-1:0]  dst_port;
        logic [WORD_W-1:0]  length;
        logic [RECV_W-1:0]  received;
    } final_t;

    // ones' complement add with end-around carry
    function automatic logic [WORD_W-1:0] add16(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
        end
    endfunction

endpackage

@@ design/urc_cfg_regs.sv @@
// configuration registers: local address and open port table
module urc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [urc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [urc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output urc_pkg::cfg_t                    cfg
);

    logic [urc_pkg::IP_W-1:0]                                  local_ip_reg;
    logic [urc_pkg::IPSUM_W-1:0]                               ip_sum_reg;
    logic [urc_pkg::REG_ENTRIES-1:0][urc_pkg::PORT_ENTRY_W-1:0] port_entry_reg;
    logic [urc_pkg::IPSUM_W-1:0]                               ip_sum_next;

    assign cfg_ready = 1'b1;

    // halves of the local address summed ahead of time, stable while idle
    assign ip_sum_next = {1'b0, local_ip_reg[urc_pkg::IP_W-1:urc_pkg::WORD_W]}
                       + {1'b0, local_ip_reg[urc_pkg::WORD_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg   <= '0;
            ip_sum_reg     <= '0;
            port_entry_reg <= '0;
        end
        else
        begin
            ip_sum_reg <= ip_sum_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == urc_pkg::CFG_LOCAL_IP)
                begin
                    local_ip_reg <= cfg_data[urc_pkg::IP_W-1:0];
                end
                for (int i = 0; i < urc_pkg::REG_ENTRIES; i++)
                begin
                    if (cfg_index == urc_pkg::CFG_PORT_BASE + urc_pkg::CFG_IDX_W'(i))
                    begin
                        port_entry_reg[i] <= cfg_data[urc_pkg::PORT_ENTRY_W-1:0];
                    end
                end
            end
        end
    end

    assign cfg.local_ip_sum = ip_sum_reg;
    assign cfg.port_entry   = port_entry_reg;

endmodule

@@ design/urc_accum.sv @@
// input register, header capture and running checksum per datagram
module urc_accum
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [urc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             fin_valid,
    input  logic                             fin_ready,
    output urc_pkg::final_t                  fin
);

    localparam int BW = urc_pkg::BYTE_W;
    localparam int WW = urc_pkg::WORD_W;

    logic                        s1_valid_reg, s1_valid_next;
    logic [BW-1:0]               s1_byte_reg;
    logic                        s1_last_reg;
    logic [urc_pkg::IP_W-1:0]    s1_ip_reg;
    logic                        s_accept, s1_go, f_hold;

    logic [urc_pkg::COUNT_W-1:0] count_reg, count_next, count_upd, idx;
    logic [WW-1:0]               run_reg, run_next, run_upd;
    logic [BW-1:0]               held_reg, held_next, held_upd;
    logic [WW-1:0]               src_reg, src_next, src_upd;
    logic [WW-1:0]               dst_reg, dst_next, dst_upd;
    logic [WW-1:0]               len_reg, len_next, len_upd;
    logic [urc_pkg::IPSUM_W-1:0] ipsum_reg, ipsum_next, ipsum_upd;
    logic                        take;

    logic                        f_valid_reg, f_valid_next;
    urc_pkg::final_t             f_reg, f_next;

    assign f_hold   = f_valid_reg && !fin_ready;
    assign s1_go    = s1_valid_reg && !(s1_last_reg && f_hold);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_accept = s_tvalid && s_tready;

    assign s1_valid_next = s_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign f_valid_next  = (s1_go && s1_last_reg) ? 1'b1 : (fin_ready ? 1'b0 : f_valid_reg);

    always_comb
    begin
        idx       = count_reg;
        src_upd   = src_reg;
        dst_upd   = dst_reg;
        len_upd   = len_reg;
        held_upd  = held_reg;
        run_upd   = run_reg;
        ipsum_upd = ipsum_reg;

        // sender address sampled on the first word
        if (idx == '0)
        begin
            ipsum_upd = {1'b0, s1_ip_reg[urc_pkg::IP_W-1:WW]} + {1'b0, s1_ip_reg[WW-1:0]};
        end

        unique case (idx)
            urc_pkg::OFS_SRC_HI: src_upd = {s1_byte_reg, {BW{1'b0}}};
            urc_pkg::OFS_SRC_LO: src_upd = {src_reg[WW-1:BW], s1_byte_reg};
            urc_pkg::OFS_DST_HI: dst_upd = {s1_byte_reg, {BW{1'b0}}};
            urc_pkg::OFS_DST_LO: dst_upd = {dst_reg[WW-1:BW], s1_byte_reg};
            urc_pkg::OFS_LEN_HI: len_upd = {s1_byte_reg, {BW{1'b0}}};
            urc_pkg::OFS_LEN_LO: len_upd = {len_reg[WW-1:BW], s1_byte_reg};
            default:             ;
        endcase

        // header always summed, payload only up to the length field
        take = (idx != '1)
            && ((idx < urc_pkg::COUNT_W'(urc_pkg::HEADER_BYTES)) || (idx < len_upd));

        if (take)
        begin
            if (!idx[0])
            begin
                held_upd = s1_byte_reg;
            end
            else
            begin
                run_upd = urc_pkg::add16(run_reg, {held_reg, s1_byte_reg});
            end
        end

        count_upd = (idx == '1) ? idx : idx + 1'b1;

        f_next.run_sum     = run_upd;
        f_next.pad_word    = len_upd[0] ? {held_upd, {BW{1'b0}}} : '0;
        f_next.ip_sum      = ipsum_upd;
        f_next.source_port = src_upd;
        f_next.dst_port    = dst_upd;
        f_next.length      = len_upd;
        f_next.received    = {1'b0, idx} + urc_pkg::RECV_W'(1);

        // per-datagram state starts over after the final word
        count_next = s1_last_reg ? '0 : count_upd;
        run_next   = s1_last_reg ? '0 : run_upd;
        held_next  = s1_last_reg ? '0 : held_upd;
        src_next   = s1_last_reg ? '0 : src_upd;
        dst_next   = s1_last_reg ? '0 : dst_upd;
        len_next   = s1_last_reg ? '0 : len_upd;
        ipsum_next = s1_last_reg ? '0 : ipsum_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            f_valid_reg  <= 1'b0;
            count_reg    <= '0;
            run_reg      <= '0;
            held_reg     <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            len_reg      <= '0;
            ipsum_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            f_valid_reg  <= f_valid_next;
            if (s1_go)
            begin
                count_reg <= count_next;
                run_reg   <= run_next;
                held_reg  <= held_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                len_reg   <= len_next;
                ipsum_reg <= ipsum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_byte_reg <= s_tdata[BW-1:0];
            s1_ip_reg   <= s_tdata[BW+urc_pkg::IP_W-1:BW];
            s1_last_reg <= s_tlast;
        end
        if (s1_go && s1_last_reg)
        begin
            f_reg <= f_next;
        end
    end

    assign fin_valid = f_valid_reg;
    assign fin       = f_reg;

endmodule

@@ design/urc_verdict.sv @@
// checksum close-out, port lookup and result register
module urc_verdict
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fin_valid,
    output logic                             fin_ready,
    input  urc_pkg::final_t                  fin,
    input  urc_pkg::cfg_t                    cfg,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [urc_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int WW = urc_pkg::WORD_W;
    localparam int TW = urc_pkg::TOTAL_W;

    logic                             out_valid_reg, out_valid_next;
    logic [urc_pkg::M_TDATA_W-1:0]    out_data_reg, out_data_next;
    logic [TW-1:0]                    total;
    logic [WW:0]                      folded;
    logic                             sum_ok, hit;
    logic [urc_pkg::ENTRY_W-1:0]      hit_index, entry;
    urc_pkg::verdict_t                verdict;
    logic                             load;

    assign fin_ready = !out_valid_reg || m_tready;
    assign load      = fin_valid && fin_ready;
    assign out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_comb
    begin
        // pseudo header terms join the payload sum; the protocol term keeps it nonzero
        total = TW'(fin.run_sum) + TW'(fin.pad_word) + TW'(fin.ip_sum)
              + TW'(cfg.local_ip_sum) + TW'(urc_pkg::UDP_PROTOCOL) + TW'(fin.length);
        folded = {1'b0, total[WW-1:0]} + (WW+1)'(total[TW-1:WW]);
        sum_ok = (folded == {1'b0, {WW{1'b1}}});

        hit       = 1'b0;
        hit_index = '0;
        for (int i = urc_pkg::SEARCH_ENTRIES - 1; i >= 0; i--)
        begin
            if (cfg.port_entry[i][WW] && (cfg.port_entry[i][WW-1:0] == fin.dst_port))
            begin
                hit       = 1'b1;
                hit_index = urc_pkg::ENTRY_W'(i);
            end
        end

        entry = '0;
        priority if (fin.received < urc_pkg::RECV_W'(urc_pkg::MIN_RECEIVED))
        begin
            verdict = urc_pkg::VERDICT_TRUNCATED;
        end
        else if (fin.length < WW'(urc_pkg::HEADER_BYTES))
        begin
            verdict = urc_pkg::VERDICT_TOO_SHORT;
        end
        else if (fin.received < {1'b0, fin.length})
        begin
            verdict = urc_pkg::VERDICT_TRUNCATED;
        end
        else if (!sum_ok)
        begin
            verdict = urc_pkg::VERDICT_BAD_CHECKSUM;
        end
        else if (hit)
        begin
            verdict = urc_pkg::VERDICT_DELIVERED;
            entry   = hit_index;
        end
        else
        begin
            verdict = urc_pkg::VERDICT_UNREACHABLE;
        end

        out_data_next = {{(urc_pkg::M_TDATA_W - urc_pkg::M_FIELD_W){1'b0}},
                         fin.length, fin.dst_port, fin.source_port, entry, verdict};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ design/udp_receive_checker.sv @@
// udp receive checker top level: checksum, length checks and port lookup
//
//  channel | direction | handshake                 | payload
//  s_*     | in        | s_tvalid / s_tready       | datagram byte, sender address, tlast
//  m_*     | out       | m_tvalid / m_tready       | verdict, entry, ports, length
//  cfg_*   | in        | cfg_valid / cfg_ready     | register index and write data
//
// one byte word per cycle unless the input stalls; the checksum is a single ones' complement add per byte pair
// the final word's result goes through the close-out register to the result register
// three registers in line: input register, close-out register, result register
// the input side keeps flowing while a result waits; it stalls only when a
// second final word finds both close-out and result registers occupied and m_tready low
// reset clears the per-datagram counters, sums and header fields, the valid flags and configuration to zero
module udp_receive_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [urc_pkg::S_TDATA_W-1:0]    s_tdata,   // data_byte[7:0], sender_ip[39:8]
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [urc_pkg::M_TDATA_W-1:0]    m_tdata,   // verdict[2:0], entry_index[4:3],
                                                        // source_port[20:5],
                                                        // destination_port[36:21],
                                                        // datagram_length[52:37], zero pad
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [urc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [urc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    urc_pkg::cfg_t   cfg;
    urc_pkg::final_t fin;
    logic            fin_valid;
    logic            fin_ready;

    urc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    urc_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    urc_verdict u_verdict
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .cfg       (cfg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ design/urc_checker.sv @@
// port-level assertions for the udp receive checker, bound to the top level
module urc_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [urc_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic [urc_pkg::VERDICT_W-1:0] verdict;
    logic [urc_pkg::ENTRY_W-1:0]   entry;
    logic [urc_pkg::WORD_W-1:0]    length;

    assign verdict = m_tdata[2:0];
    assign entry   = m_tdata[4:3];
    assign length  = m_tdata[52:37];

    // stalled result holds still
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> verdict <= urc_pkg::VERDICT_TRUNCATED)
        else $error("verdict code out of range");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && verdict != urc_pkg::VERDICT_DELIVERED |-> entry == '0)
        else $error("entry index set without delivery");

    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && verdict == urc_pkg::VERDICT_TOO_SHORT
            |-> length < urc_pkg::WORD_W'(urc_pkg::HEADER_BYTES))
        else $error("too short verdict with a full length");

    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && verdict == urc_pkg::VERDICT_DELIVERED
            |-> length >= urc_pkg::WORD_W'(urc_pkg::HEADER_BYTES))
        else $error("delivered with a short length");

endmodule

bind udp_receive_checker urc_checker u_urc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
